/* hdl/atcl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atcl_pkg: shared types and constants of the AT command line decoder
// Command codes, line store geometry, the decoder sequencer states and the command word tables.
// ----------------------------------------------------------------------------
package atcl_pkg;

	localparam int LINE_LEN = 64;
	localparam int IDX_W = $clog2(LINE_LEN);
	localparam logic [15:0] PWM_LIMIT_RST = 16'd1000;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_QUEST = 8'd63;
	localparam logic [7:0] CH_EQ = 8'd61;
	localparam int NUM_WORDS = 13;

	// candidate word indexes that need extra handling
	localparam logic [3:0] WORD_MOTOR = 4'd3;
	localparam logic [3:0] WORD_ACC = 4'd6;
	localparam logic [3:0] WORD_MAXVEL = 4'd7;
	localparam logic [3:0] WORD_PATHPOS = 4'd8;
	localparam logic [3:0] WORD_PATHVEL = 4'd9;
	localparam logic [3:0] WORD_PWM = 4'd10;

	typedef enum logic [3:0] {
		CMD_ERROR = 4'd0, CMD_PING = 4'd1, CMD_SHUT = 4'd2, CMD_LIVE = 4'd3,
		CMD_BUILD = 4'd4, CMD_ID_QUERY = 4'd5, CMD_ID_SET = 4'd6,
		CMD_FREQ = 4'd7, CMD_LIST = 4'd8, CMD_ACC = 4'd9, CMD_MAXVEL = 4'd10,
		CMD_PATHPOS = 4'd11, CMD_PATHVEL = 4'd12, CMD_PWM = 4'd13,
		CMD_DEBUG = 4'd14, CMD_LIMIT = 4'd15
	} cmd_t;

	typedef enum logic [2:0] {
		ST_COLLECT, ST_PREFIX, ST_WORD, ST_NUM, ST_CHECK, ST_OUT
	} state_t;

	// word length (bytes after "AT+")
	function automatic logic [3:0] word_len(input logic [3:0] w);
		unique case (w)
			4'd0: word_len = 4'd4;   // shut
			4'd1: word_len = 4'd4;   // live
			4'd2: word_len = 4'd6;   // build query
			4'd3: word_len = 4'd8;   // motor id
			4'd4: word_len = 4'd13;  // control frequency query
			4'd5: word_len = 4'd10;  // list values
			4'd6: word_len = 4'd4;   // acceleration
			4'd7: word_len = 4'd8;   // max velocity
			4'd8: word_len = 4'd9;   // path position
			4'd9: word_len = 4'd9;   // path velocity
			4'd10: word_len = 4'd4;  // pwm
			4'd11: word_len = 4'd5;  // debug
			4'd12: word_len = 4'd6;  // limit query
			default: word_len = 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] word_char(input logic [3:0] w, input logic [3:0] i);
		logic [103:0] s;
		unique case (w)
			4'd0: s = {"SHUT", 72'd0};
			4'd1: s = {"LIVE", 72'd0};
			4'd2: s = {"BUILD?", 56'd0};
			4'd3: s = {"MOTOR_", "ID", 40'd0};
			4'd4: s = {"CONTROL_", "FREQ?"};
			4'd5: s = {"LIST_", "VALUE", 24'd0};
			4'd6: s = {"ACC=", 72'd0};
			4'd7: s = {"MAX_VEL=", 40'd0};
			4'd8: s = {"PATH_", "POS=", 32'd0};
			4'd9: s = {"PATH_", "VEL=", 32'd0};
			4'd10: s = {"PWM=", 72'd0};
			4'd11: s = {"DEBUG", 64'd0};
			4'd12: s = {"LIMIT?", 56'd0};
			default: s = '0;
		endcase
		word_char = s[8'd103 - {i, 3'b000} -: 8];
	endfunction

	function automatic cmd_t word_cmd(input logic [3:0] w);
		unique case (w)
			4'd0: word_cmd = CMD_SHUT;
			4'd1: word_cmd = CMD_LIVE;
			4'd2: word_cmd = CMD_BUILD;
			4'd3: word_cmd = CMD_ID_SET;
			4'd4: word_cmd = CMD_FREQ;
			4'd5: word_cmd = CMD_LIST;
			4'd6: word_cmd = CMD_ACC;
			4'd7: word_cmd = CMD_MAXVEL;
			4'd8: word_cmd = CMD_PATHPOS;
			4'd9: word_cmd = CMD_PATHVEL;
			4'd10: word_cmd = CMD_PWM;
			4'd11: word_cmd = CMD_DEBUG;
			4'd12: word_cmd = CMD_LIMIT;
			default: word_cmd = CMD_ERROR;
		endcase
	endfunction

endpackage
`default_nettype wire

/* hdl/at_command_line_decoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// at_command_line_decoder_core: AT command line decoder
// Collects bytes into a line store and decodes the line at carriage return.
// ----------------------------------------------------------------------------
// A byte that is not a carriage return is written to the 64-entry line
// store and the write index advances (wrapping). A carriage return starts
// the decoder: a sequencer walks the store one byte per cycle through a
// registered read port, a single byte compare unit and a single
// multiply-by-ten accumulator. It checks the "AT+" prefix byte by byte,
// compares bytes against each candidate command word (words tried in
// order), takes the argument digits through the accumulator and, after an
// argument, runs a check step. The result item is then held on
// command/argument until taken; rx_ready stays low while decoding and while
// the result waits.
// ----------------------------------------------------------------------------
module at_command_line_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       command,
	output logic [31:0]      argument,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] pwm_limit
);

	localparam int IW = atcl_pkg::IDX_W;

	logic [7:0] mem_q [atcl_pkg::LINE_LEN];
	logic [IW-1:0] wr_idx_q;
	logic [IW:0] len_q;    // latched line length (0..63 due to wrap)
	logic [7:0] byte11_q;  // copy of store entry 11 (motor id separator)
	logic [15:0] pwm_lim_q;
	logic [3:0] motor_q;
	atcl_pkg::state_t st_q, st_d;
	logic [IW-1:0] rd_idx_q, rd_idx_d;
	logic [7:0] rd_data_q;
	logic [3:0] word_q, word_d;
	logic [3:0] pos_q, pos_d;
	logic [31:0] acc_q, acc_d;
	logic neg_q, neg_d;
	logic first_q, first_d;
	logic [3:0] cmd_q, cmd_d;
	logic [31:0] arg_q, arg_d;
	logic motor_wr;
	logic [IW:0] wl_end;
	logic [31:0] acc_x10;
	logic [31:0] sval;
	logic signed [32:0] s33, lim33;

	assign cfg_ready = 1'b1;
	assign rx_ready = (st_q == atcl_pkg::ST_COLLECT);
	assign out_valid = (st_q == atcl_pkg::ST_OUT);
	assign command = cmd_q;
	assign argument = arg_q;

	// store bytes; read the entry the sequencer moves to next, so rd_data_q
	// holds the byte at rd_idx_q while the line is decoded
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready && rx_byte != atcl_pkg::CH_CR) begin
			mem_q[wr_idx_q] <= rx_byte;
		end
		rd_data_q <= mem_q[rd_idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			byte11_q <= '0;
			pwm_lim_q <= atcl_pkg::PWM_LIMIT_RST;
			motor_q <= '0;
			st_q <= atcl_pkg::ST_COLLECT;
			rd_idx_q <= '0;
			word_q <= '0;
			pos_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			first_q <= 1'b0;
			cmd_q <= '0;
			arg_q <= '0;
			len_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) pwm_lim_q <= pwm_limit;
			if (motor_wr) motor_q <= sval[3:0];
			if (rx_valid && rx_ready) begin
				if (rx_byte == atcl_pkg::CH_CR) begin
					len_q <= {1'b0, wr_idx_q};
					wr_idx_q <= '0;
				end else begin
					if (wr_idx_q == IW'(11)) byte11_q <= rx_byte;
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
			st_q <= st_d;
			rd_idx_q <= rd_idx_d;
			word_q <= word_d;
			pos_q <= pos_d;
			acc_q <= acc_d;
			neg_q <= neg_d;
			first_q <= first_d;
			cmd_q <= cmd_d;
			arg_q <= arg_d;
		end
	end

	assign wl_end = (IW+1)'(3) + (IW+1)'(atcl_pkg::word_len(word_q));
	assign acc_x10 = (acc_q << 3) + (acc_q << 1) + 32'(rd_data_q - atcl_pkg::CH_ZERO);
	assign sval = neg_q ? (32'd0 - acc_q) : acc_q;
	assign s33 = {sval[31], sval};
	assign lim33 = {17'd0, pwm_lim_q};

	always_comb begin
		st_d = st_q;
		rd_idx_d = rd_idx_q;
		word_d = word_q;
		pos_d = pos_q;
		acc_d = acc_q;
		neg_d = neg_q;
		first_d = first_q;
		cmd_d = cmd_q;
		arg_d = arg_q;
		motor_wr = 1'b0;
		unique case (st_q)
			atcl_pkg::ST_COLLECT: begin
				if (rx_valid && rx_byte == atcl_pkg::CH_CR) begin
					cmd_d = atcl_pkg::CMD_ERROR;
					arg_d = '0;
					rd_idx_d = '0;
					st_d = atcl_pkg::ST_PREFIX;
				end
			end
			// check "AT+" one byte per cycle (a bare "AT" line is a ping)
			atcl_pkg::ST_PREFIX: begin
				priority if (len_q < (IW+1)'(2)) begin
					st_d = atcl_pkg::ST_OUT;
				end else if (rd_idx_q == IW'(0) && rd_data_q != "A") begin
					st_d = atcl_pkg::ST_OUT;
				end else if (rd_idx_q == IW'(1) && rd_data_q != "T") begin
					st_d = atcl_pkg::ST_OUT;
				end else if (rd_idx_q == IW'(1) && len_q == (IW+1)'(2)) begin
					cmd_d = atcl_pkg::CMD_PING;
					st_d = atcl_pkg::ST_OUT;
				end else if (rd_idx_q == IW'(2)) begin
					if (rd_data_q == atcl_pkg::CH_PLUS) begin
						word_d = '0;
						pos_d = '0;
						rd_idx_d = IW'(3);
						st_d = atcl_pkg::ST_WORD;
					end else begin
						st_d = atcl_pkg::ST_OUT;
					end
				end else begin
					rd_idx_d = rd_idx_q + 1'b1;
				end
			end
			// compare candidate word byte by byte
			atcl_pkg::ST_WORD: begin
				if (word_q == 4'(atcl_pkg::NUM_WORDS)) begin
					st_d = atcl_pkg::ST_OUT;
				end else if (wl_end > len_q ||
						rd_data_q != atcl_pkg::word_char(word_q, pos_q)) begin
					word_d = word_q + 1'b1;
					pos_d = '0;
					rd_idx_d = IW'(3);
				end else if (pos_q + 1'b1 == atcl_pkg::word_len(word_q)) begin
					// matched
					rd_idx_d = wl_end[IW-1:0];
					acc_d = '0;
					neg_d = 1'b0;
					first_d = 1'b1;
					unique case (word_q)
						atcl_pkg::WORD_MOTOR: begin
							if (len_q == (IW+1)'(12) &&
									byte11_q == atcl_pkg::CH_QUEST) begin
								cmd_d = atcl_pkg::CMD_ID_QUERY;
								arg_d = 32'(motor_q) + 32'd1;
								st_d = atcl_pkg::ST_OUT;
							end else if (len_q >= (IW+1)'(12) &&
									byte11_q == atcl_pkg::CH_EQ) begin
								rd_idx_d = IW'(12);
								st_d = (len_q == (IW+1)'(12)) ?
									atcl_pkg::ST_OUT : atcl_pkg::ST_NUM;
							end else begin
								st_d = atcl_pkg::ST_OUT;
							end
						end
						atcl_pkg::WORD_ACC, atcl_pkg::WORD_MAXVEL,
						atcl_pkg::WORD_PATHPOS, atcl_pkg::WORD_PATHVEL,
						atcl_pkg::WORD_PWM: begin
							st_d = (wl_end >= len_q) ? atcl_pkg::ST_OUT : atcl_pkg::ST_NUM;
						end
						default: begin
							cmd_d = atcl_pkg::word_cmd(word_q);
							st_d = atcl_pkg::ST_OUT;
						end
					endcase
				end else begin
					pos_d = pos_q + 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
				end
			end
			// one digit per cycle through the shared accumulator
			atcl_pkg::ST_NUM: begin
				if (first_q && rd_data_q == atcl_pkg::CH_MINUS) begin
					neg_d = 1'b1;
					first_d = 1'b0;
					rd_idx_d = rd_idx_q + 1'b1;
					if ({1'b0, rd_idx_q} + 1'b1 == len_q) st_d = atcl_pkg::ST_CHECK;
				end else if (rd_data_q < atcl_pkg::CH_ZERO ||
						rd_data_q > atcl_pkg::CH_NINE) begin
					st_d = atcl_pkg::ST_OUT;
				end else begin
					first_d = 1'b0;
					acc_d = acc_x10;
					rd_idx_d = rd_idx_q + 1'b1;
					if ({1'b0, rd_idx_q} + 1'b1 == len_q) st_d = atcl_pkg::ST_CHECK;
				end
			end
			atcl_pkg::ST_CHECK: begin
				st_d = atcl_pkg::ST_OUT;
				unique case (word_q)
					atcl_pkg::WORD_MOTOR: begin
						if (sval <= 32'd15) begin
							motor_wr = 1'b1;
							cmd_d = atcl_pkg::CMD_ID_SET;
							arg_d = sval;
						end
					end
					atcl_pkg::WORD_PWM: begin
						if (s33 >= -lim33 && s33 <= lim33) begin
							cmd_d = atcl_pkg::CMD_PWM;
							arg_d = sval;
						end
					end
					default: begin
						cmd_d = atcl_pkg::word_cmd(word_q);
						arg_d = sval;
					end
				endcase
			end
			atcl_pkg::ST_OUT: begin
				if (out_ready) st_d = atcl_pkg::ST_COLLECT;
			end
			default: st_d = atcl_pkg::ST_COLLECT;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/atcl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atcl_checker: port-level checks of the AT command line decoder
// Watches the handshakes and result item ordering.
// ----------------------------------------------------------------------------
module atcl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rx_valid,
	input wire logic        rx_ready,
	input wire logic [7:0]  rx_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  command,
	input wire logic [31:0] argument
);

	// never take a byte while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && rx_ready)) else $error("input taken during result");

	// a result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) && $stable(argument))
		else $error("result dropped");

	// carriage return stops intake
	a_cr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready && rx_byte == atcl_pkg::CH_CR |=> !rx_ready)
		else $error("still ready after line end");

	// plain bytes keep intake open
	a_byte_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready && rx_byte != atcl_pkg::CH_CR |=> rx_ready && !out_valid)
		else $error("stall after plain byte");

endmodule

bind at_command_line_decoder_core atcl_checker u_atcl_checker (
	.clk(clk), .arst_n(arst_n), .rx_valid(rx_valid), .rx_ready(rx_ready),
	.rx_byte(rx_byte), .out_valid(out_valid), .out_ready(out_ready),
	.command(command), .argument(argument)
);
`default_nettype wire
